FILE: hdl/bapp_pkg.sv
// bapp_pkg: shared types and constants for the binomial american put pricer
// no dependencies
`default_nettype none
package bapp_pkg;

  localparam int unsigned PriceW  = 48;
  localparam int unsigned FactorW = 32;
  localparam int unsigned DepthW  = 7;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [PriceW-1:0] PriceMax = {PriceW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_TREE_DEPTH = 3'd0,
    REG_DOWN       = 3'd1,
    REG_UOD        = 3'd2,
    REG_PU         = 3'd3,
    REG_PD         = 3'd4,
    REG_DISC       = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LSP_MUL,
    ST_LSP_WB,
    ST_LEAF_MUL,
    ST_LEAF_WB,
    ST_NODE_RD,
    ST_NODE_UP,
    ST_NODE_DN,
    ST_NODE_STK,
    ST_NODE_DISC,
    ST_NODE_WB,
    ST_RD_ROOT,
    ST_DONE
  } seq_state_e;

  // shared multiplier request
  typedef struct packed {
    logic [PriceW-1:0]  val;
    logic [FactorW-1:0] fac;
  } mul_req_t;

  typedef struct packed {
    logic [PriceW-1:0] res;
    logic              sat;
  } mul_rsp_t;

  function automatic logic [PriceW-1:0] put_payoff(
    input logic [PriceW-1:0] stock,
    input logic [PriceW-1:0] strike
  );
    put_payoff = (strike > stock) ? (strike - stock) : '0;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/bapp_mul.sv
// bapp_mul: registered q2.30 multiply of a 48-bit price, saturated to 48 bits
// depends on bapp_pkg
`default_nettype none
module bapp_mul (
  input  wire logic           clk_i,
  input  bapp_pkg::mul_req_t  req_i,
  output bapp_pkg::mul_rsp_t  rsp_o
);
  // two 24x32 partial products, one register after them
  logic [55:0] hi_q, lo_q;
  logic [56:0] sum;
  logic [49:0] r;

  always_ff @(posedge clk_i) begin
    hi_q <= 56'(req_i.val[47:24]) * 56'(req_i.fac);
    lo_q <= 56'(req_i.val[23:0]) * 56'(req_i.fac);
  end

  assign sum = {1'b0, hi_q[5:0], 24'd0} + 57'(lo_q);
  assign r   = 50'(hi_q[55:6]) + 50'(sum[56:30]);

  always_comb begin
    rsp_o.sat = |r[49:48];
    rsp_o.res = rsp_o.sat ? bapp_pkg::PriceMax : r[47:0];
  end
endmodule
`default_nettype wire

FILE: hdl/binomial_american_put_pricer.sv
// binomial_american_put_pricer: top level, sequencer, node and price memories
// depends on bapp_pkg and bapp_mul
// usage: write the six model registers through cfg_we_i/cfg_idx_i/cfg_data_i
// while idle. pulse start_i with spot_price_i and strike_price_i while busy_o
// is low; the beat is taken at that edge. busy_o stays high for the whole
// request. when done, done_o is high for one cycle carrying option_value_o
// and saturated_o; the receiver cannot stall and needs none.
// every step runs through one registered 48x32 multiplier: the level-start
// prices first, then the leaves, then backward induction over D*(D+1)/2
// nodes, and last the root read; done_o rises in the cycle in which busy_o
// falls. the multiplier loop sets the rate.
// reset restores the register defaults (depth 7, factors 1.0, probabilities
// 0.5) and idles the block; the memories need no clearing.
`default_nettype none
module binomial_american_put_pricer #(
  parameter int unsigned MAX_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [47:0] spot_price_i,
  input  wire logic [47:0] strike_price_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             done_o,
  output logic [47:0]      option_value_o,
  output logic             saturated_o
);
  localparam int unsigned AW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned Pw = bapp_pkg::PriceW;

  logic [6:0]  depth_q;
  logic [31:0] down_q, uod_q;
  logic [30:0] pu_q, pd_q, disc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= 7'd7;
      down_q  <= 32'h4000_0000;
      uod_q   <= 32'h4000_0000;
      pu_q    <= 31'h2000_0000;
      pd_q    <= 31'h2000_0000;
      disc_q  <= 31'h4000_0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bapp_pkg::REG_TREE_DEPTH: depth_q <= cfg_data_i[6:0];
        bapp_pkg::REG_DOWN:       down_q  <= cfg_data_i;
        bapp_pkg::REG_UOD:        uod_q   <= cfg_data_i;
        bapp_pkg::REG_PU:         pu_q    <= cfg_data_i[30:0];
        bapp_pkg::REG_PD:         pd_q    <= cfg_data_i[30:0];
        bapp_pkg::REG_DISC:       disc_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // memories
  logic [Pw-1:0] lsp_mem [MAX_DEPTH+1];
  logic [Pw-1:0] nv_mem  [MAX_DEPTH+1];
  logic          lsp_we, nv_we;
  logic [AW-1:0] lsp_wa, lsp_ra, nv_wa, nv_ra;
  logic [Pw-1:0] lsp_wd, nv_wd, lsp_rd_q, nv_rd_q;

  always_ff @(posedge clk_i) begin
    if (lsp_we) lsp_mem[lsp_wa] <= lsp_wd;
    lsp_rd_q <= lsp_mem[lsp_ra];
  end
  always_ff @(posedge clk_i) begin
    if (nv_we) nv_mem[nv_wa] <= nv_wd;
    nv_rd_q <= nv_mem[nv_ra];
  end

  bapp_pkg::mul_req_t mreq;
  bapp_pkg::mul_rsp_t mrsp;
  bapp_mul u_mul (.clk_i(clk_i), .req_i(mreq), .rsp_o(mrsp));

  bapp_pkg::seq_state_e st_q, st_d;
  logic [AW-1:0] dep_q, dep_d, i_q, i_d, j_q, j_d;
  logic [Pw-1:0] spot_q, spot_d, strike_q, strike_d, stock_q, stock_d;
  logic [Pw-1:0] acc_q, acc_d, vup_q, vup_d, res_q, res_d;
  logic          sat_q, sat_d, done_q, done_d;
  logic [Pw:0]   esum;
  logic [Pw-1:0] cont;

  assign esum = {1'b0, acc_q} + {1'b0, mrsp.res};
  assign cont = mrsp.res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= bapp_pkg::ST_IDLE;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      dep_q  <= '0;
      i_q    <= '0;
      j_q    <= '0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
      sat_q  <= sat_d;
      dep_q  <= dep_d;
      i_q    <= i_d;
      j_q    <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    spot_q   <= spot_d;
    strike_q <= strike_d;
    stock_q  <= stock_d;
    acc_q    <= acc_d;
    vup_q    <= vup_d;
    res_q    <= res_d;
  end

  always_comb begin
    st_d = st_q; dep_d = dep_q; i_d = i_q; j_d = j_q;
    spot_d = spot_q; strike_d = strike_q; stock_d = stock_q;
    acc_d = acc_q; vup_d = vup_q; res_d = res_q; sat_d = sat_q;
    done_d = 1'b0;
    lsp_we = 1'b0; lsp_wa = i_q; lsp_wd = mrsp.res; lsp_ra = i_q;
    nv_we = 1'b0;  nv_wa = j_q;  nv_wd = '0;       nv_ra = j_q;
    mreq.val = stock_q; mreq.fac = uod_q;
    case (st_q)
      bapp_pkg::ST_IDLE: begin
        if (start_i) begin
          spot_d = spot_price_i; strike_d = strike_price_i;
          stock_d = spot_price_i; sat_d = 1'b0;
          dep_d = (32'(depth_q) > MAX_DEPTH) ? AW'(MAX_DEPTH) : AW'(depth_q);
          i_d = '0;
          lsp_we = 1'b1; lsp_wa = '0; lsp_wd = spot_price_i;
          st_d = bapp_pkg::ST_LSP_MUL;
        end
      end
      bapp_pkg::ST_LSP_MUL: begin
        mreq.fac = down_q;
        if (i_q == dep_q) begin
          j_d = '0;
          nv_we = 1'b1; nv_wa = '0;
          nv_wd = bapp_pkg::put_payoff(stock_q, strike_q);
          st_d = (dep_q == '0) ? bapp_pkg::ST_RD_ROOT : bapp_pkg::ST_LEAF_MUL;
        end else begin
          st_d = bapp_pkg::ST_LSP_WB;
        end
      end
      bapp_pkg::ST_LSP_WB: begin
        sat_d = sat_q | mrsp.sat;
        stock_d = mrsp.res;
        i_d = i_q + 1'b1;
        lsp_we = 1'b1; lsp_wa = i_q + 1'b1;
        st_d = bapp_pkg::ST_LSP_MUL;
      end
      bapp_pkg::ST_LEAF_MUL: st_d = bapp_pkg::ST_LEAF_WB;
      bapp_pkg::ST_LEAF_WB: begin
        sat_d = sat_q | mrsp.sat;
        stock_d = mrsp.res;
        j_d = j_q + 1'b1;
        nv_we = 1'b1; nv_wa = j_q + 1'b1;
        nv_wd = bapp_pkg::put_payoff(mrsp.res, strike_q);
        if (j_q + 1'b1 == dep_q) begin
          i_d = dep_q - 1'b1; j_d = '0;
          st_d = bapp_pkg::ST_NODE_RD;
        end else begin
          st_d = bapp_pkg::ST_LEAF_MUL;
        end
      end
      // node (i,j): read V[j+1] then V[j]; stock from level start or walk
      bapp_pkg::ST_NODE_RD: begin
        nv_ra = j_q + 1'b1; lsp_ra = i_q;
        st_d = bapp_pkg::ST_NODE_UP;
      end
      bapp_pkg::ST_NODE_UP: begin
        nv_ra = j_q;
        vup_d = nv_rd_q;
        if (j_q == '0) stock_d = lsp_rd_q;
        mreq.val = nv_rd_q; mreq.fac = {1'b0, pu_q};
        st_d = bapp_pkg::ST_NODE_DN;
      end
      bapp_pkg::ST_NODE_DN: begin
        sat_d = sat_q | mrsp.sat;
        acc_d = mrsp.res;
        mreq.val = nv_rd_q; mreq.fac = {1'b0, pd_q};
        st_d = bapp_pkg::ST_NODE_STK;
      end
      bapp_pkg::ST_NODE_STK: begin
        sat_d = sat_q | mrsp.sat | esum[Pw];
        acc_d = esum[Pw] ? bapp_pkg::PriceMax : esum[Pw-1:0];
        // walk the stock along the level (not for the first node)
        mreq.val = stock_q; mreq.fac = uod_q;
        st_d = bapp_pkg::ST_NODE_DISC;
      end
      bapp_pkg::ST_NODE_DISC: begin
        if (j_q != '0) begin
          sat_d = sat_q | mrsp.sat;
          stock_d = mrsp.res;
        end
        mreq.val = acc_q; mreq.fac = {1'b0, disc_q};
        st_d = bapp_pkg::ST_NODE_WB;
      end
      bapp_pkg::ST_NODE_WB: begin
        sat_d = sat_q | mrsp.sat;
        vup_d = bapp_pkg::put_payoff(stock_q, strike_q);
        nv_we = 1'b1; nv_wa = j_q;
        nv_wd = (vup_d > cont) ? vup_d : cont;
        if (j_q == i_q) begin
          j_d = '0;
          if (i_q == '0) st_d = bapp_pkg::ST_RD_ROOT;
          else begin
            i_d = i_q - 1'b1;
            st_d = bapp_pkg::ST_NODE_RD;
          end
        end else begin
          j_d = j_q + 1'b1;
          st_d = bapp_pkg::ST_NODE_RD;
        end
      end
      bapp_pkg::ST_RD_ROOT: begin
        nv_ra = '0;
        st_d = bapp_pkg::ST_DONE;
      end
      bapp_pkg::ST_DONE: begin
        res_d = nv_rd_q;
        done_d = 1'b1;
        st_d = bapp_pkg::ST_IDLE;
      end
      default: st_d = bapp_pkg::ST_IDLE;
    endcase
  end

  assign busy_o         = (st_q != bapp_pkg::ST_IDLE);
  assign done_o         = done_q;
  assign option_value_o = res_q;
  assign saturated_o    = sat_q;
endmodule
`default_nettype wire

FILE: sim/bapp_checker.sv
// bapp_checker: watches the config, request and result ports of the put pricer,
// predicts each root value and saturation flag, and counts mismatches
// depends on bapp_pkg
`default_nettype none
module bapp_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic [47:0] spot_price_i,
  input  wire logic [47:0] strike_price_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        done_i,
  input  wire logic [47:0] option_value_i,
  input  wire logic        saturated_i,
  output int               errors_o,
  output int               pending_o
);

  localparam int unsigned TreeMax = 64;
  localparam int unsigned PriceW  = bapp_pkg::PriceW;
  localparam int unsigned FactorW = bapp_pkg::FactorW;
  localparam int unsigned DepthW  = bapp_pkg::DepthW;

  typedef struct {
    logic [PriceW-1:0] value;
    logic              sat;
  } put_result_t;

  logic [DepthW-1:0]  depth_q;
  logic [FactorW-1:0] down_q, uod_q;
  logic [30:0]        pu_q, pd_q, disc_q;

  put_result_t put_q[$];

  // {sat, floor(v*f / 2^30)} clamped to 48 bits
  function automatic logic [PriceW:0] scale_q30(input logic [PriceW-1:0] v,
                                                 input logic [FactorW-1:0] f);
    logic [79:0] p;
    p = ({32'd0, v} * {48'd0, f}) >> 30;
    if (p > {32'd0, bapp_pkg::PriceMax}) return {1'b1, bapp_pkg::PriceMax};
    return {1'b0, p[PriceW-1:0]};
  endfunction

  function automatic logic [PriceW:0] clamp_sum(input logic [PriceW:0] s);
    if (s > {1'b0, bapp_pkg::PriceMax}) return {1'b1, bapp_pkg::PriceMax};
    return {1'b0, s[PriceW-1:0]};
  endfunction

  function automatic logic [PriceW-1:0] exercise(input logic [PriceW-1:0] stock,
                                                 input logic [PriceW-1:0] strike);
    return (strike > stock) ? strike - stock : '0;
  endfunction

  function automatic put_result_t price_put(input logic [PriceW-1:0] spot,
                                            input logic [PriceW-1:0] strike);
    logic [PriceW-1:0] lvl_price [0:TreeMax];
    logic [PriceW-1:0] node [0:TreeMax];
    logic [PriceW:0]   r, up_part, dn_part, sum;
    logic [PriceW-1:0] stock, hold;
    logic              sat;
    int                d;
    put_result_t       res;
    sat = 1'b0;
    d = (depth_q > TreeMax) ? TreeMax : int'(depth_q);
    lvl_price[0] = spot;
    for (int i = 1; i <= d; i++) begin
      r = scale_q30(lvl_price[i-1], down_q);
      sat |= r[PriceW];
      lvl_price[i] = r[PriceW-1:0];
    end
    stock = lvl_price[d];
    for (int j = 0; j <= d; j++) begin
      if (j > 0) begin
        r = scale_q30(stock, uod_q);
        sat |= r[PriceW];
        stock = r[PriceW-1:0];
      end
      node[j] = exercise(stock, strike);
    end
    for (int i = d; i > 0; i--) begin
      stock = lvl_price[i-1];
      for (int j = 0; j <= i - 1; j++) begin
        if (j > 0) begin
          r = scale_q30(stock, uod_q);
          sat |= r[PriceW];
          stock = r[PriceW-1:0];
        end
        up_part = scale_q30(node[j+1], {1'b0, pu_q});
        dn_part = scale_q30(node[j], {1'b0, pd_q});
        sat |= up_part[PriceW] | dn_part[PriceW];
        sum = clamp_sum({1'b0, up_part[PriceW-1:0]} + {1'b0, dn_part[PriceW-1:0]});
        sat |= sum[PriceW];
        r = scale_q30(sum[PriceW-1:0], {1'b0, disc_q});
        sat |= r[PriceW];
        hold = exercise(stock, strike);
        node[j] = (hold > r[PriceW-1:0]) ? hold : r[PriceW-1:0];
      end
    end
    res.value = node[0];
    res.sat = sat;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    put_result_t got;
    int          n;
    if (!rst_ni) begin
      depth_q  <= 7'd7;
      down_q   <= 32'h4000_0000;
      uod_q    <= 32'h4000_0000;
      pu_q     <= 31'h2000_0000;
      pd_q     <= 31'h2000_0000;
      disc_q   <= 31'h4000_0000;
      put_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      n = put_q.size();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bapp_pkg::REG_TREE_DEPTH: depth_q <= cfg_data_i[DepthW-1:0];
          bapp_pkg::REG_DOWN:       down_q  <= cfg_data_i;
          bapp_pkg::REG_UOD:        uod_q   <= cfg_data_i;
          bapp_pkg::REG_PU:         pu_q    <= cfg_data_i[30:0];
          bapp_pkg::REG_PD:         pd_q    <= cfg_data_i[30:0];
          bapp_pkg::REG_DISC:       disc_q  <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (done_i) begin
        if (n == 0) begin
          $display("%0t: result beat with nothing expected, value %h sat %b", $time,
                   option_value_i, saturated_i);
          errors_o <= errors_o + 1;
        end else begin
          got = put_q.pop_front();
          n--;
          if (got.value !== option_value_i || got.sat !== saturated_i) begin
            $display("%0t: option_value expected %h actual %h, saturated expected %b actual %b",
                     $time, got.value, option_value_i, got.sat, saturated_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        put_q.push_back(price_put(spot_price_i, strike_price_i));
        n++;
      end
      pending_o <= n;
    end
  end

endmodule
`default_nettype wire

FILE: sim/binomial_american_put_pricer_tb.sv
// binomial_american_put_pricer_tb: drives config writes and pricing requests,
// the checker beside the block predicts and compares; verdict printed here
// depends on bapp_pkg, binomial_american_put_pricer and bapp_checker
`default_nettype none
module binomial_american_put_pricer_tb;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam logic [2:0] RegSpare  = 3'd6;
  localparam int         StallLimit = 200000;
  localparam int         RandItems = 85;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [47:0] spot_price_i = '0;
  logic [47:0] strike_price_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        busy_o, done_o, saturated_o;
  logic [47:0] option_value_o;
  int          errors, pending;
  int          stall_cnt = 0;
  bit          quiet;

  initial forever #5 clk_i = ~clk_i;

  binomial_american_put_pricer uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .spot_price_i, .strike_price_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .done_o, .option_value_o, .saturated_o
  );

  bapp_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .spot_price_i, .strike_price_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .done_i(done_o), .option_value_i(option_value_o),
    .saturated_i(saturated_o), .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt > StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic write_model(input logic [6:0] d, input logic [31:0] dn, input logic [31:0] uod,
                             input logic [31:0] pu, input logic [31:0] pd,
                             input logic [31:0] disc);
    // junk in the unused upper bits of the depth register
    write_reg(bapp_pkg::REG_TREE_DEPTH, {$urandom} & 32'hFFFF_FF80 | {25'd0, d});
    write_reg(bapp_pkg::REG_DOWN, dn);
    write_reg(bapp_pkg::REG_UOD, uod);
    write_reg(bapp_pkg::REG_PU, pu);
    write_reg(bapp_pkg::REG_PD, pd);
    write_reg(bapp_pkg::REG_DISC, disc);
  endtask

  task automatic send(input logic [47:0] spot, input logic [47:0] strike);
    bit b;
    if (!quiet && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 16)) @(posedge clk_i);
    @(posedge clk_i);
    start_i        <= 1'b1;
    spot_price_i   <= spot;
    strike_price_i <= strike;
    do begin
      @(negedge clk_i);
      b = busy_o;
      @(posedge clk_i);
    end while (b);
    start_i <= 1'b0;
  endtask

  // block is idle once every result is back; a few spare cycles before writes
  task automatic drain();
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic realistic_model(input logic [6:0] d);
    logic [31:0] pu;
    pu = $urandom_range(32'h1000_0000, 32'h3000_0000);
    write_model(d, 32'h4000_0000 - $urandom_range(0, 32'h0800_0000),
                32'h4000_0000 + $urandom_range(0, 32'h1000_0000), pu,
                32'h4000_0000 - pu, 32'h4000_0000 - $urandom_range(0, 32'h0040_0000));
  endtask

  task automatic realistic_item();
    logic [47:0] spot, strike;
    spot = {24'($urandom_range(1, 400)), 24'($urandom)};
    strike = {24'($urandom_range(1, 400)), 24'($urandom)};
    send(spot, strike);
  endtask

  initial begin
    int       sent, n;
    bit       deep;
    quiet = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset model: field extremes
    send('0, '0);
    send(bapp_pkg::PriceMax, bapp_pkg::PriceMax);
    send('0, bapp_pkg::PriceMax);
    send(bapp_pkg::PriceMax, '0);
    send(48'h64_000000, 48'h6E_000000);
    drain();
    // single leaf, unknown index write ignored
    write_model(7'd0, 32'h3C00_0000, 32'h4800_0000, 32'h2000_0000, 32'h2000_0000, 32'h4000_0000);
    write_reg(RegUnused, $urandom);
    write_reg(RegSpare, $urandom);
    send(48'h50_000000, 48'h64_000000);
    send(bapp_pkg::PriceMax, 48'h1);
    drain();
    // deepest tree, then depth above the maximum clamps
    realistic_model(7'd64);
    realistic_item();
    drain();
    realistic_model(7'd127);
    realistic_item();
    drain();
    // probabilities and discount above one: expectation saturates
    write_model(7'd5, 32'h3F00_0000, 32'h4200_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send('0, bapp_pkg::PriceMax);
    send(48'h10_000000, 48'hFF_0000_0000);
    drain();
    // factors at the top: stock walk saturates
    write_model(7'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h2000_0000, 32'h2000_0000, 32'h4000_0000);
    send(bapp_pkg::PriceMax, bapp_pkg::PriceMax);
    send(48'h1, 48'h1000);
    drain();
    // zero factors
    write_model(7'd4, '0, '0, '0, '0, '0);
    send(48'h20_000000, 48'h30_000000);
    send(bapp_pkg::PriceMax, '0);
    drain();

    sent = 0;
    while (sent < RandItems) begin
      quiet = (sent > RandItems * 4 / 5);
      deep = ($urandom_range(0, 11) == 0);
      if ($urandom_range(0, 4) != 0) begin
        realistic_model(deep ? 7'($urandom_range(40, 127)) : 7'($urandom_range(0, 12)));
      end else begin
        write_model(deep ? 7'($urandom_range(40, 127)) : 7'($urandom_range(0, 10)),
                    $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      n = deep ? 1 : $urandom_range(3, 10);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) send(rand48(), rand48());
        else realistic_item();
        sent++;
      end
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
